/* hdl/record_bubble_sort_by_key_assert.svh */
// ----------------------------------------------------------------------------
// Record sorter assertion macros
// Shared concurrent assertion forms for the record sorter.
// ----------------------------------------------------------------------------
`ifndef RECORD_BUBBLE_SORT_BY_KEY_ASSERT_SVH
`define RECORD_BUBBLE_SORT_BY_KEY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("record sorter check failed");

// Next-cycle implication, disabled during reset.
`define RBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("record sorter check failed");

`endif

/* hdl/rbs_pkg.sv */
// ----------------------------------------------------------------------------
// Record sorter package
// Record layout and sort key codes shared by the sorter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rbs_pkg;

  localparam int unsigned TAG_W     = 8;
  localparam int unsigned SNAME_H_W = 64;
  localparam int unsigned SNAME_L_W = 48;
  localparam int unsigned BOOK_W    = 31;
  localparam int unsigned MARK_W    = 4;
  localparam int unsigned NUM_MARKS = 5;
  localparam int unsigned KEY_W     = 3;

  // Sort key codes; anything else sorts by surname.
  localparam logic [KEY_W-1:0] KEY_SURNAME = 3'd0;
  localparam logic [KEY_W-1:0] KEY_MARK1   = 3'd1;
  localparam logic [KEY_W-1:0] KEY_MARK2   = 3'd2;
  localparam logic [KEY_W-1:0] KEY_MARK3   = 3'd3;
  localparam logic [KEY_W-1:0] KEY_MARK4   = 3'd4;
  localparam logic [KEY_W-1:0] KEY_MARK5   = 3'd5;

  // One stored record; mark one sits in the low nibble of marks.
  typedef struct packed {
    logic [TAG_W-1:0]              tag;
    logic [SNAME_H_W-1:0]          surname_high;
    logic [SNAME_L_W-1:0]          surname_low;
    logic [BOOK_W-1:0]             book_id;
    logic [NUM_MARKS*MARK_W-1:0]   marks;
  } record_t;

endpackage : rbs_pkg

`default_nettype wire

/* hdl/rbs_key_compare.sv */
// ----------------------------------------------------------------------------
// Record sorter key compare
// Decides whether the left record of an adjacent pair must move right.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_key_compare
  import rbs_pkg::*;
(
  input  wire logic [KEY_W-1:0] key,
  input  wire record_t          rec_a,
  input  wire record_t          rec_b,
  output logic                  swap
);

  logic              name_gt;
  logic [MARK_W-1:0] mark_a;
  logic [MARK_W-1:0] mark_b;
  logic              by_mark;

  // 112-bit unsigned surname compare
  assign name_gt = {rec_a.surname_high, rec_a.surname_low} >
                   {rec_b.surname_high, rec_b.surname_low};

  always_comb begin
    by_mark = 1'b1;
    mark_a  = '0;
    mark_b  = '0;
    unique case (key)
      KEY_MARK1: begin
        mark_a = rec_a.marks[0*MARK_W +: MARK_W];
        mark_b = rec_b.marks[0*MARK_W +: MARK_W];
      end
      KEY_MARK2: begin
        mark_a = rec_a.marks[1*MARK_W +: MARK_W];
        mark_b = rec_b.marks[1*MARK_W +: MARK_W];
      end
      KEY_MARK3: begin
        mark_a = rec_a.marks[2*MARK_W +: MARK_W];
        mark_b = rec_b.marks[2*MARK_W +: MARK_W];
      end
      KEY_MARK4: begin
        mark_a = rec_a.marks[3*MARK_W +: MARK_W];
        mark_b = rec_b.marks[3*MARK_W +: MARK_W];
      end
      KEY_MARK5: begin
        mark_a = rec_a.marks[4*MARK_W +: MARK_W];
        mark_b = rec_b.marks[4*MARK_W +: MARK_W];
      end
      default: begin
        by_mark = 1'b0;
      end
    endcase
  end

  // Mark descending, surname ascending on equal marks; surname alone for other keys.
  assign swap = by_mark ? ((mark_a < mark_b) || ((mark_a == mark_b) && name_gt))
                        : name_gt;

endmodule : rbs_key_compare

`default_nettype wire

/* hdl/record_bubble_sort_by_key.sv */
// ----------------------------------------------------------------------------
// Record bubble sort by key
// Loads records into a record memory, bubble-sorts in place, streams result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one record word per cycle while
//   the block is loading. Each word is written to the record memory; words
//   past MAX_RECORDS are dropped. A word with in_final_record set ends the
//   batch: in_stall goes high and the stored records are sorted in place.
//   Sorting: each pass walks the memory once, one record a cycle, carrying
//   the record that sorts later in a register (read i, write i-1). Passes
//   repeat until one makes no swap, so at most n passes for n records; the
//   single memory port pair serves every read and write of the sort.
//   Emission: records leave on out_valid / out_stall in sorted order, and
//   the next is read only once the current is taken; out_last marks the
//   last one. A stall holds the output word; the block waits.
//   cfg_write_en / cfg_sort_key set the key: 0 surname ascending, 1..5 the
//   chosen mark descending with surname tiebreak. Write only while idle.
//   Reset (rst_n low, synchronous) holds in_stall, empties batch, key 0.
// ----------------------------------------------------------------------------
`default_nettype none

module record_bubble_sort_by_key
  import rbs_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_write_en,
  input  wire logic [KEY_W-1:0]     cfg_sort_key,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [TAG_W-1:0]     in_tag,
  input  wire logic [SNAME_H_W-1:0] in_surname_high,
  input  wire logic [SNAME_L_W-1:0] in_surname_low,
  input  wire logic [BOOK_W-1:0]    in_book_id,
  input  wire logic [MARK_W-1:0]    in_mark_one,
  input  wire logic [MARK_W-1:0]    in_mark_two,
  input  wire logic [MARK_W-1:0]    in_mark_three,
  input  wire logic [MARK_W-1:0]    in_mark_four,
  input  wire logic [MARK_W-1:0]    in_mark_five,
  input  wire logic                 in_final_record,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [TAG_W-1:0]          out_tag,
  output logic [SNAME_H_W-1:0]      out_surname_high,
  output logic [SNAME_L_W-1:0]      out_surname_low,
  output logic [BOOK_W-1:0]         out_book_id,
  output logic [MARK_W-1:0]         out_mark_one,
  output logic [MARK_W-1:0]         out_mark_two,
  output logic [MARK_W-1:0]         out_mark_three,
  output logic [MARK_W-1:0]         out_mark_four,
  output logic [MARK_W-1:0]         out_mark_five,
  output logic                      out_last
);

  localparam int unsigned AW = $clog2(MAX_RECORDS);      // memory address
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);  // record count
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_RECORDS);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,  // loading
    S_P_FIRST = 7'b0000010,  // capture entry 0 into carry
    S_P_RUN   = 7'b0000100,  // compare carry with entry i, write i-1
    S_P_END   = 7'b0001000,  // write carry to n-1
    S_EM_RD   = 7'b0010000,  // read entry for output
    S_EM_CAP  = 7'b0100000,  // load output register
    S_EM_HOLD = 7'b1000000   // wait for receiver
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            swapped_r, swapped_nxt;
  logic [KEY_W-1:0] key_r;
  record_t         carry_r, carry_nxt;
  record_t         rdata_r;
  record_t         out_rec_r, out_rec_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_valid_r, out_valid_nxt;

  // record memory
  record_t         mem [MAX_RECORDS];
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            we;
  logic [AW-1:0]   wr_addr;
  record_t         wr_data;

  record_t         in_rec;
  logic            swap;
  logic            is_last;
  logic [CW-1:0]   cnt_inc;

  assign in_rec.tag          = in_tag;
  assign in_rec.surname_high = in_surname_high;
  assign in_rec.surname_low  = in_surname_low;
  assign in_rec.book_id      = in_book_id;
  assign in_rec.marks        = {in_mark_five, in_mark_four, in_mark_three,
                                in_mark_two, in_mark_one};

  // idx points at the last stored record
  assign is_last = (CW'(idx_r) == (count_r - CW'(1)));
  assign cnt_inc = (count_r == CNT_FULL) ? count_r : (count_r + CW'(1));

  rbs_key_compare u_cmp (
    .key   (key_r),
    .rec_a (carry_r),
    .rec_b (rdata_r),
    .swap  (swap)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    swapped_nxt   = swapped_r;
    carry_nxt     = carry_r;
    out_rec_nxt   = out_rec_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    we            = 1'b0;
    wr_addr       = idx_r;
    wr_data       = carry_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (count_r != CNT_FULL) begin
            we      = 1'b1;
            wr_addr = count_r[AW-1:0];
            wr_data = in_rec;
          end
          count_nxt = cnt_inc;
          if (in_final_record) begin
            idx_nxt = '0;
            if (cnt_inc == CW'(1)) begin
              state_nxt = S_EM_RD;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_P_FIRST;
            end
          end
        end
      end
      S_P_FIRST: begin
        carry_nxt   = rdata_r;
        swapped_nxt = 1'b0;
        rd_en       = 1'b1;
        rd_addr     = AW'(1);
        idx_nxt     = AW'(1);
        state_nxt   = S_P_RUN;
      end
      S_P_RUN: begin
        we      = 1'b1;
        wr_addr = idx_r - AW'(1);
        if (swap) begin
          wr_data     = rdata_r;   // carry keeps moving right
          swapped_nxt = 1'b1;
        end else begin
          wr_data   = carry_r;
          carry_nxt = rdata_r;
        end
        if (is_last) begin
          state_nxt = S_P_END;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r + AW'(1);
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_P_END: begin
        we        = 1'b1;
        wr_addr   = idx_r;
        wr_data   = carry_r;
        rd_en     = 1'b1;   // entry 0 for next pass or first output
        rd_addr   = '0;
        idx_nxt   = '0;
        state_nxt = swapped_r ? S_P_FIRST : S_EM_CAP;
      end
      S_EM_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_EM_CAP;
      end
      S_EM_CAP: begin
        out_rec_nxt   = rdata_r;
        out_last_nxt  = is_last;
        out_valid_nxt = 1'b1;
        state_nxt     = S_EM_HOLD;
      end
      S_EM_HOLD: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = idx_r + AW'(1);
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_EM_CAP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      swapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      key_r       <= KEY_SURNAME;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      swapped_r   <= swapped_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        key_r <= cfg_sort_key;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    carry_r    <= carry_nxt;
    out_rec_r  <= out_rec_nxt;
    out_last_r <= out_last_nxt;
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // no word is taken while reset is held
  assign in_stall         = !rst_n || (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_tag          = out_rec_r.tag;
  assign out_surname_high = out_rec_r.surname_high;
  assign out_surname_low  = out_rec_r.surname_low;
  assign out_book_id      = out_rec_r.book_id;
  assign out_mark_one     = out_rec_r.marks[0*MARK_W +: MARK_W];
  assign out_mark_two     = out_rec_r.marks[1*MARK_W +: MARK_W];
  assign out_mark_three   = out_rec_r.marks[2*MARK_W +: MARK_W];
  assign out_mark_four    = out_rec_r.marks[3*MARK_W +: MARK_W];
  assign out_mark_five    = out_rec_r.marks[4*MARK_W +: MARK_W];
  assign out_last         = out_last_r;

  // ------------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------------
`include "record_bubble_sort_by_key_assert.svh"

  // no result word while loading
  `RBS_ASSERT_IMPL(a_no_out_while_loading, clk, rst_n, !in_stall, !out_valid)
  // the final word closes the input channel
  `RBS_ASSERT_NEXT(a_final_closes_input, clk, rst_n,
    in_valid && !in_stall && in_final_record, in_stall)
  // sort writes stay inside the batch
  `RBS_ASSERT_IMPL(a_sort_write_in_batch, clk, rst_n,
    we && (state_r != S_IDLE), CW'(wr_addr) < count_r)
  // fill count never passes the memory depth
  `RBS_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_FULL)

endmodule : record_bubble_sort_by_key

`default_nettype wire

/* verif/record_bubble_sort_by_key_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Record bubble sort by key testbench
// Loads batches of records under every sort key, checks that each batch
// comes back in the right order, with stable ties, against an in-bench
// sorter.
// ----------------------------------------------------------------------------

module record_bubble_sort_by_key_tb
  import rbs_pkg::*;
();

  // Store depth of the block under test; batches longer than this lose words.
  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned NAME_W = SNAME_H_W + SNAME_L_W;
  localparam int unsigned MARKS_W = NUM_MARKS * MARK_W;

  // Keys with no meaning of their own; the block sorts by surname for them.
  localparam logic [KEY_W-1:0] KEY_UNUSED6 = 3'd6;
  localparam logic [KEY_W-1:0] KEY_UNUSED7 = 3'd7;

  // The worst quiet stretch is a full store sort (up to 64 passes) or the long
  // output hold; the limit is several times either.
  localparam int unsigned WATCHDOG_LIMIT = 50000;
  localparam int unsigned IDLE_SETTLE = 8;   // after the last owed result word is back
  localparam int unsigned END_SETTLE = 40;
  localparam int unsigned LONG_HOLD = 400;   // receiver hold in the pressure test
  localparam int unsigned RANDOM_WORDS = 200;

  typedef struct {
    record_t rec;
    bit last;
  } sorted_word_t;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} drain_pattern_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_write_en = 1'b0;
  logic [KEY_W-1:0] cfg_sort_key = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TAG_W-1:0] in_tag = '0;
  logic [SNAME_H_W-1:0] in_surname_high = '0;
  logic [SNAME_L_W-1:0] in_surname_low = '0;
  logic [BOOK_W-1:0] in_book_id = '0;
  logic [MARK_W-1:0] in_mark_one = '0;
  logic [MARK_W-1:0] in_mark_two = '0;
  logic [MARK_W-1:0] in_mark_three = '0;
  logic [MARK_W-1:0] in_mark_four = '0;
  logic [MARK_W-1:0] in_mark_five = '0;
  logic in_final_record = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TAG_W-1:0] out_tag;
  logic [SNAME_H_W-1:0] out_surname_high;
  logic [SNAME_L_W-1:0] out_surname_low;
  logic [BOOK_W-1:0] out_book_id;
  logic [MARK_W-1:0] out_mark_one;
  logic [MARK_W-1:0] out_mark_two;
  logic [MARK_W-1:0] out_mark_three;
  logic [MARK_W-1:0] out_mark_four;
  logic [MARK_W-1:0] out_mark_five;
  logic out_last;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  record_t pending_batch[$];        // records loaded since the last final word
  sorted_word_t expected_sorted[$]; // words the block still owes us, in order
  logic [KEY_W-1:0] key_setting = KEY_SURNAME;
  logic [NAME_W-1:0] name_pool[4];  // shared surnames, refreshed by the random tests
  int unsigned error_count = 0;
  int unsigned send_burst_left = 0;
  int unsigned hold_requests = 0;   // bumped by the pressure test

  record_bubble_sort_by_key #(
    .MAX_RECORDS(STORE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_write_en(cfg_write_en),
    .cfg_sort_key(cfg_sort_key),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_tag(in_tag),
    .in_surname_high(in_surname_high),
    .in_surname_low(in_surname_low),
    .in_book_id(in_book_id),
    .in_mark_one(in_mark_one),
    .in_mark_two(in_mark_two),
    .in_mark_three(in_mark_three),
    .in_mark_four(in_mark_four),
    .in_mark_five(in_mark_five),
    .in_final_record(in_final_record),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_tag(out_tag),
    .out_surname_high(out_surname_high),
    .out_surname_low(out_surname_low),
    .out_book_id(out_book_id),
    .out_mark_one(out_mark_one),
    .out_mark_two(out_mark_two),
    .out_mark_three(out_mark_three),
    .out_mark_four(out_mark_four),
    .out_mark_five(out_mark_five),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Record builders
  // --------------------------------------------------------------------------

  // Big-endian, zero-padded surname from text.
  function automatic logic [NAME_W-1:0] pack_name(input string s);
    logic [NAME_W-1:0] nm;
    nm = '0;
    for (int i = 0; i < s.len() && i < NAME_W / 8; i++) begin
      nm[NAME_W-1-8*i -: 8] = s[i];
    end
    return nm;
  endfunction

  // Upper-case name of 1..14 letters.
  function automatic logic [NAME_W-1:0] letter_name();
    logic [NAME_W-1:0] nm;
    int len;
    nm = '0;
    len = $urandom_range(1, NAME_W / 8);
    for (int i = 0; i < len; i++) begin
      nm[NAME_W-1-8*i -: 8] = 8'($urandom_range(8'h41, 8'h5A));
    end
    return nm;
  endfunction

  function automatic record_t make_record(input logic [TAG_W-1:0] tag,
                                          input logic [NAME_W-1:0] nm,
                                          input logic [BOOK_W-1:0] book,
                                          input logic [MARKS_W-1:0] marks);
    record_t r;
    r.tag = tag;
    {r.surname_high, r.surname_low} = nm;
    r.book_id = book;
    r.marks = marks;
    return r;
  endfunction

  // Random record. Surnames mix full-width noise, exact ties from the pool,
  // pool names with only the low bytes changed, and plain letter names.
  // Marks are often squeezed to two bits so mark ties are common.
  function automatic record_t random_record();
    logic [127:0] wide;
    logic [NAME_W-1:0] nm;
    logic [MARKS_W-1:0] marks;
    int pick;
    wide = {$urandom, $urandom, $urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      nm = wide[NAME_W-1:0];
    end else if (pick < 6) begin
      nm = name_pool[$urandom_range(0, 3)];
    end else if (pick < 8) begin
      nm = name_pool[$urandom_range(0, 3)];
      nm[SNAME_L_W-1:0] = wide[SNAME_L_W-1:0];
    end else begin
      nm = letter_name();
    end
    marks = MARKS_W'($urandom);
    if ($urandom_range(0, 1) == 1) begin
      marks &= 20'h33333;
    end
    return make_record(TAG_W'($urandom), nm, BOOK_W'($urandom), marks);
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one record word per call, plus the in-bench sorter
  // --------------------------------------------------------------------------

  // Sender runs in bursts; a new burst may open with a gap of idle cycles.
  // Once the word is taken it is filed; a final word closes the batch and
  // turns it into the expected sorted words.
  task automatic send_record(input record_t r, input bit last);
    int unsigned gap;
    record_t order[$];
    record_t cur;
    record_t prev;
    logic [MARK_W-1:0] mark_cur;
    logic [MARK_W-1:0] mark_prev;
    int j;
    sorted_word_t w;
    if (send_burst_left == 0) begin
      send_burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    send_burst_left--;
    in_valid <= 1'b1;
    in_tag <= r.tag;
    in_surname_high <= r.surname_high;
    in_surname_low <= r.surname_low;
    in_book_id <= r.book_id;
    in_mark_one <= r.marks[0*MARK_W +: MARK_W];
    in_mark_two <= r.marks[1*MARK_W +: MARK_W];
    in_mark_three <= r.marks[2*MARK_W +: MARK_W];
    in_mark_four <= r.marks[3*MARK_W +: MARK_W];
    in_mark_five <= r.marks[4*MARK_W +: MARK_W];
    in_final_record <= last;
    do @(posedge clk); while (in_stall !== 1'b0);

    // Words past the store depth are dropped, a final one included,
    // but a final word still releases the batch.
    if (pending_batch.size() < STORE_DEPTH) begin
      pending_batch.push_back(r);
    end
    if (!last) begin
      return;
    end

    // Stable insertion sort. Order: chosen mark descending (mark keys only),
    // then surname as a 112-bit unsigned value ascending, then load order.
    order = pending_batch;
    for (int i = 1; i < order.size(); i++) begin
      cur = order[i];
      j = i;
      while (j > 0) begin
        prev = order[j-1];
        mark_cur = '0;
        mark_prev = '0;
        if (key_setting >= KEY_MARK1 && key_setting <= KEY_MARK5) begin
          mark_cur = cur.marks[(key_setting - KEY_MARK1) * MARK_W +: MARK_W];
          mark_prev = prev.marks[(key_setting - KEY_MARK1) * MARK_W +: MARK_W];
        end
        if (mark_prev < mark_cur ||
            (mark_prev == mark_cur &&
             {prev.surname_high, prev.surname_low} >
             {cur.surname_high, cur.surname_low})) begin
          order[j] = prev;
          j--;
        end else begin
          break;
        end
      end
      order[j] = cur;
    end
    foreach (order[k]) begin
      w.rec = order[k];
      w.last = (k == order.size() - 1);
      expected_sorted.push_back(w);
    end
    pending_batch.delete();
  endtask

  // Drop valid, let every owed word come back, then let the block settle
  // back into loading.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_sorted.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Key changes only between batches, with the block idle.
  task automatic write_sort_key(input logic [KEY_W-1:0] key);
    wait_idle();
    cfg_write_en <= 1'b1;
    cfg_sort_key <= key;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    key_setting = key;
  endtask

  // --------------------------------------------------------------------------
  // Output side: receiver stall pattern and result checker
  // --------------------------------------------------------------------------

  // The stall pattern is redrawn at random; FLOW_FREE gives stretches with no
  // stall at all. A hold request overrides it with a long stall set by LONG_HOLD.
  drain_pattern_t drain_pattern = FLOW_FREE;
  int unsigned pattern_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_served = 0;
  int unsigned drain_cycle = 0;

  always @(posedge clk) begin
    drain_cycle++;
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        drain_pattern = drain_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(16, 160);
      end
      pattern_left--;
      case (drain_pattern)
        FLOW_FREE: begin
          out_stall <= 1'b0;
        end
        FLOW_LIGHT: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        FLOW_HEAVY: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall <= (drain_cycle % 4 != 0);
        end
      endcase
    end
  end

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endtask

  // Every accepted result word is matched against the oldest owed word.
  always @(posedge clk) begin
    sorted_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_sorted.size() == 0) begin
        error_count++;
        $error("result word with tag 0x%0h arrived with nothing owed", out_tag);
      end else begin
        want = expected_sorted.pop_front();
        check_field("out_tag", want.rec.tag, out_tag);
        check_field("out_surname_high", want.rec.surname_high, out_surname_high);
        check_field("out_surname_low", want.rec.surname_low, out_surname_low);
        check_field("out_book_id", want.rec.book_id, out_book_id);
        check_field("out_mark_one", want.rec.marks[0*MARK_W +: MARK_W], out_mark_one);
        check_field("out_mark_two", want.rec.marks[1*MARK_W +: MARK_W], out_mark_two);
        check_field("out_mark_three", want.rec.marks[2*MARK_W +: MARK_W], out_mark_three);
        check_field("out_mark_four", want.rec.marks[3*MARK_W +: MARK_W], out_mark_four);
        check_field("out_mark_five", want.rec.marks[4*MARK_W +: MARK_W], out_mark_five);
        check_field("out_last", want.last, out_last);
      end
    end
  end

  // Watchdog: too long without any word moving on either channel.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("record_bubble_sort_by_key test failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Surname order at key 0: all-zero and all-ones records, names that differ
  // only after a zero byte, names equal in the high word that differ in the
  // low word, and a repeated name that must keep its load order.
  task automatic test_surname_order();
    logic [NAME_W-1:0] gap_c;
    logic [NAME_W-1:0] gap_d;
    gap_c = pack_name("AB");
    gap_c[NAME_W-1-8*3 -: 8] = "C";
    gap_d = pack_name("AB");
    gap_d[NAME_W-1-8*3 -: 8] = "D";
    write_sort_key(KEY_SURNAME);
    send_record(make_record(8'h00, '0, '0, '0), 1'b0);
    send_record(make_record(8'hFF, '1, '1, '1), 1'b0);
    send_record(make_record(8'h01, gap_c, 31'd11, 20'h12345), 1'b0);
    send_record(make_record(8'h02, gap_d, 31'd12, 20'h54321), 1'b0);
    send_record(make_record(8'h03, pack_name("HIGHSAMEX"), 31'd13, 20'hABCDE), 1'b0);
    send_record(make_record(8'h04, pack_name("HIGHSAMEA"), 31'd14, 20'hEDCBA), 1'b0);
    send_record(make_record(8'h05, gap_c, 31'd15, 20'h0F0F0), 1'b1);
  endtask

  // One-record batch under the top unused key.
  task automatic test_single_record();
    write_sort_key(KEY_UNUSED7);
    send_record(make_record(8'h5A, pack_name("SOLO"), 31'h2AAAAAAA, 20'hA5A5A), 1'b1);
  endtask

  // Two records per key: on odd keys the later surname has the higher mark
  // and must lead; on even keys the marks tie and surname decides. Key 6
  // ignores marks altogether.
  task automatic test_mark_keys();
    logic [MARKS_W-1:0] marks_late;
    logic [MARKS_W-1:0] marks_early;
    int sel;
    for (int k = KEY_MARK1; k <= KEY_UNUSED6; k++) begin
      marks_late = MARKS_W'($urandom);
      marks_early = MARKS_W'($urandom);
      if (k <= KEY_MARK5) begin
        sel = k - KEY_MARK1;
        marks_late[sel*MARK_W +: MARK_W] = 4'd9;
        marks_early[sel*MARK_W +: MARK_W] = (k % 2 == 1) ? 4'd3 : 4'd9;
      end
      write_sort_key(KEY_W'(k));
      send_record(make_record(8'(8'h10 + k), pack_name("ZIMA"), BOOK_W'(k), marks_late),
                  1'b0);
      send_record(make_record(8'(8'h20 + k), pack_name("ADAMS"), BOOK_W'(k), marks_early),
                  1'b1);
    end
  endtask

  // Fill the store and go two words past it; the last of them is the final
  // word, which is dropped but still starts the sort.
  task automatic test_store_overflow();
    write_sort_key(KEY_MARK2);
    foreach (name_pool[p]) name_pool[p] = letter_name();
    for (int i = 0; i < STORE_DEPTH + 2; i++) begin
      send_record(random_record(), i == STORE_DEPTH + 1);
    end
  endtask

  // Random batches under random keys. Most batches are short; a few are
  // medium and a rare one comes near, reaches or passes the store depth.
  task automatic test_random_batches();
    int unsigned sent;
    int unsigned batches;
    int unsigned size;
    int unsigned roll;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      write_sort_key(KEY_W'($urandom_range(0, 7)));
      batches = $urandom_range(1, 4);
      repeat (batches) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          size = $urandom_range(1, 8);
        end else if (roll < 97) begin
          size = $urandom_range(9, 24);
        end else begin
          size = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 2);
        end
        foreach (name_pool[p]) name_pool[p] = letter_name();
        for (int i = 0; i < size; i++) begin
          send_record(random_record(), i == size - 1);
        end
        sent += size;
      end
    end
  endtask

  // Receiver holds off while the first batch is due out; the sender keeps
  // offering the next batch, so the block backs up and stalls its input.
  task automatic test_output_hold();
    write_sort_key(KEY_MARK5);
    foreach (name_pool[p]) name_pool[p] = letter_name();
    for (int i = 0; i < 10; i++) begin
      send_record(random_record(), i == 9);
    end
    hold_requests++;
    for (int i = 0; i < 12; i++) begin
      send_record(random_record(), i == 11);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_surname_order();
    test_single_record();
    test_mark_keys();
    test_store_overflow();
    test_random_batches();
    test_output_hold();
    wait_idle();
    repeat (END_SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("record_bubble_sort_by_key test passed");
    end else begin
      $display("record_bubble_sort_by_key test failed");
    end
    $finish;
  end

endmodule

/* record_bubble_sort_by_key.f */
+incdir+hdl
hdl/rbs_pkg.sv
hdl/rbs_key_compare.sv
hdl/record_bubble_sort_by_key.sv
verif/record_bubble_sort_by_key_tb.sv
